@@ design/vrm_pkg.sv @@
`timescale 1ns / 1ps

package vrm_pkg;

    // data and configuration widths
    localparam int DATA_W    = 64;
    localparam int HALF_W    = 32;
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 2;
    localparam int OP_W      = 2;
    localparam int VLEN_W    = 11;
    localparam int NSRC_W    = 7;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_REDUCE_OP     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDE_MODE     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VECTOR_LENGTH = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_SOURCES   = 2'd3;

    // combining operations, the unused code sums
    localparam logic [OP_W-1:0] OP_MAX = 2'd0;
    localparam logic [OP_W-1:0] OP_MIN = 2'd1;
    localparam logic [OP_W-1:0] OP_SUM = 2'd2;

    // reset values of the registers
    localparam logic [OP_W-1:0]   RST_REDUCE_OP     = OP_SUM;
    localparam logic              RST_WIDE_MODE     = 1'b1;
    localparam logic [VLEN_W-1:0] RST_VECTOR_LENGTH = 11'd1;
    localparam logic [NSRC_W-1:0] RST_NUM_SOURCES   = 7'd1;

    // per-word control flags from the sequencer
    typedef struct packed {
        logic first;   // first source: store the word without combining
        logic emit;    // last source: the reduced word goes out
        logic last;    // final index of the vector
    } t_item_ctl;

    // sign-extend the low half of a word
    function automatic logic [DATA_W-1:0] sext32(input logic [DATA_W-1:0] v);
        return {{(DATA_W-HALF_W){v[HALF_W-1]}}, v[HALF_W-1:0]};
    endfunction

endpackage

@@ design/vector_reduce_max_min_sum_core.sv @@
`timescale 1ns / 1ps

// channel   direction  handshake           payload
// input     in         i_valid / o_stall   i_element_value
// output    out        o_valid / i_stall   o_reduced_value, o_element_index, o_last_element
// config    in         i_cfg_we            i_cfg_index, i_cfg_data
//
// one word per cycle when not stalled; a word is read from accumulator memory at acceptance,
// combined and written back as the combine stage advances, the result registered for output
// back-to-back writes to the same index (length one) are forwarded around the memory
// synchronous active-low reset clears counters and valids, sets config; memory is not cleared
// a stalled result waits in the output register while one more word moves into the
// combine stage; the input stalls only when that stage also holds a result
module vector_reduce_max_min_sum_core #(
    parameter int MAX_VECTOR_LEN = 1024,
    parameter int MAX_SOURCES    = 64,
    localparam int IW = (MAX_VECTOR_LEN > 1) ? $clog2(MAX_VECTOR_LEN) : 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [vrm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [vrm_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [vrm_pkg::DATA_W-1:0]    i_element_value,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [vrm_pkg::DATA_W-1:0]    o_reduced_value,
    output logic [IW-1:0]                 o_element_index,
    output logic                          o_last_element
);
    import vrm_pkg::*;

    logic [OP_W-1:0]   op;
    logic              wide;
    logic [IW-1:0]     col;
    logic [IW-1:0]     len_m1;
    t_item_ctl         ctl;
    logic              accept;
    logic              s1_hold;
    logic              s1_adv;
    logic              fwd_hit;
    logic [DATA_W-1:0] rdata;
    logic [DATA_W-1:0] acc;
    logic [DATA_W-1:0] result;

    // combine stage
    logic              r_s1_valid;
    t_item_ctl         r_s1_ctl;
    logic [IW-1:0]     r_s1_col;
    logic [DATA_W-1:0] r_s1_x;

    // write that landed on the same edge as the current read
    logic              r_fwd_valid;
    logic [IW-1:0]     r_fwd_addr;
    logic [DATA_W-1:0] r_fwd_data;

    // output register
    logic              r_out_valid;
    logic [DATA_W-1:0] r_out_value;
    logic [IW-1:0]     r_out_index;
    logic              r_out_last;

    vrm_seq #(
        .MAX_VECTOR_LEN (MAX_VECTOR_LEN),
        .MAX_SOURCES    (MAX_SOURCES)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_adv       (accept),
        .o_op        (op),
        .o_wide      (wide),
        .o_col       (col),
        .o_len_m1    (len_m1),
        .o_ctl       (ctl)
    );

    // handshake and stage movement
    assign s1_hold = r_s1_valid && r_s1_ctl.emit && r_out_valid && i_stall;
    assign s1_adv  = r_s1_valid && !s1_hold;
    assign o_stall = s1_hold;
    assign accept  = i_valid && !o_stall;

    vrm_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_VECTOR_LEN)
    ) u_acc_ram (
        .i_clk   (i_clk),
        .i_we    (s1_adv),
        .i_waddr (r_s1_col),
        .i_wdata (result),
        .i_re    (accept),
        .i_raddr (col),
        .o_rdata (rdata)
    );

    // forward a write that raced the read of the same entry
    assign fwd_hit = r_fwd_valid && (r_fwd_addr == r_s1_col);
    assign acc     = fwd_hit ? r_fwd_data : rdata;

    vrm_alu u_alu (
        .i_op     (op),
        .i_wide   (wide),
        .i_first  (r_s1_ctl.first),
        .i_acc    (acc),
        .i_x      (r_s1_x),
        .o_result (result)
    );

    // stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_fwd_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_valid  <= 1'b1;
                r_fwd_valid <= s1_adv;
            end else if (s1_adv) begin
                r_s1_valid  <= 1'b0;
            end
            if (s1_adv && r_s1_ctl.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_ctl   <= ctl;
            r_s1_col   <= col;
            r_s1_x     <= i_element_value;
            r_fwd_addr <= r_s1_col;
            r_fwd_data <= result;
        end
        if (s1_adv && r_s1_ctl.emit) begin
            r_out_value <= result;
            r_out_index <= r_s1_col;
            r_out_last  <= r_s1_ctl.last;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_reduced_value = r_out_value;
    assign o_element_index = r_out_index;
    assign o_last_element  = r_out_last;

    // a same-edge hit on one entry only happens for a one-element vector
    a_fwd_len_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && fwd_hit |-> len_m1 == '0)
        else $error("forwarding hit with vector length above one");

    // the last flag goes with the final index
    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_last |-> r_out_index == len_m1)
        else $error("last flag on an index other than the final one");

    // no result leaves right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !r_s1_valid)
        else $error("pipeline not empty after reset");

endmodule

@@ design/vrm_ram.sv @@
`timescale 1ns / 1ps

module vrm_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/vrm_seq.sv @@
`timescale 1ns / 1ps

module vrm_seq #(
    parameter int MAX_VECTOR_LEN = 1024,
    parameter int MAX_SOURCES    = 64,
    localparam int IW = (MAX_VECTOR_LEN > 1) ? $clog2(MAX_VECTOR_LEN) : 1,
    localparam int SW = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [vrm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [vrm_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          i_adv,
    output logic [vrm_pkg::OP_W-1:0]      o_op,
    output logic                          o_wide,
    output logic [IW-1:0]                 o_col,
    output logic [IW-1:0]                 o_len_m1,
    output vrm_pkg::t_item_ctl            o_ctl
);
    import vrm_pkg::*;

    logic [OP_W-1:0]   r_op;
    logic              r_wide;
    logic [VLEN_W-1:0] r_vlen;
    logic [NSRC_W-1:0] r_nsrc;
    logic [IW-1:0]     r_col, n_col;
    logic [SW-1:0]     r_src, n_src;
    logic [IW-1:0]     len_m1;
    logic [SW-1:0]     src_m1;

    // effective length and source count, zero acts as one, large values saturate
    always_comb begin
        if (r_vlen == '0) begin
            len_m1 = '0;
        end else if (32'(r_vlen) > 32'(MAX_VECTOR_LEN)) begin
            len_m1 = IW'(MAX_VECTOR_LEN - 1);
        end else begin
            len_m1 = IW'(r_vlen - 1'b1);
        end
        if (r_nsrc == '0) begin
            src_m1 = '0;
        end else if (32'(r_nsrc) > 32'(MAX_SOURCES)) begin
            src_m1 = SW'(MAX_SOURCES - 1);
        end else begin
            src_m1 = SW'(r_nsrc - 1'b1);
        end
    end

    // index runs fastest, source steps at the end of each vector
    always_comb begin
        if (r_col == len_m1) begin
            n_col = '0;
            n_src = (r_src == src_m1) ? '0 : r_src + 1'b1;
        end else begin
            n_col = r_col + 1'b1;
            n_src = r_src;
        end
    end

    // configuration registers and position counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op   <= RST_REDUCE_OP;
            r_wide <= RST_WIDE_MODE;
            r_vlen <= RST_VECTOR_LENGTH;
            r_nsrc <= RST_NUM_SOURCES;
            r_col  <= '0;
            r_src  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_REDUCE_OP:     r_op   <= i_cfg_data[OP_W-1:0];
                REG_WIDE_MODE:     r_wide <= i_cfg_data[0];
                REG_VECTOR_LENGTH: r_vlen <= i_cfg_data[VLEN_W-1:0];
                REG_NUM_SOURCES:   r_nsrc <= i_cfg_data[NSRC_W-1:0];
                default:           r_op   <= r_op;
            endcase
            // any write restarts the stream
            r_col <= '0;
            r_src <= '0;
        end else if (i_adv) begin
            r_col <= n_col;
            r_src <= n_src;
        end
    end

    assign o_op      = r_op;
    assign o_wide    = r_wide;
    assign o_col     = r_col;
    assign o_len_m1  = len_m1;
    assign o_ctl.first = (r_src == '0);
    assign o_ctl.emit  = (r_src == src_m1);
    assign o_ctl.last  = (r_col == len_m1);

endmodule

@@ design/vrm_alu.sv @@
`timescale 1ns / 1ps

module vrm_alu (
    input  logic [vrm_pkg::OP_W-1:0]   i_op,
    input  logic                       i_wide,
    input  logic                       i_first,
    input  logic [vrm_pkg::DATA_W-1:0] i_acc,
    input  logic [vrm_pkg::DATA_W-1:0] i_x,
    output logic [vrm_pkg::DATA_W-1:0] o_result
);
    import vrm_pkg::*;

    logic [DATA_W-1:0] xn;
    logic [DATA_W-1:0] comb;
    logic [DATA_W-1:0] wrapped;

    // narrow mode takes the low half as a signed word
    assign xn = i_wide ? i_x : sext32(i_x);

    // signed max, signed min or wrapping sum
    always_comb begin
        case (i_op)
            OP_MAX:  comb = ($signed(i_acc) < $signed(xn)) ? xn : i_acc;
            OP_MIN:  comb = ($signed(xn) < $signed(i_acc)) ? xn : i_acc;
            default: comb = i_acc + xn;
        endcase
    end

    assign wrapped  = i_wide ? comb : sext32(comb);
    assign o_result = i_first ? xn : wrapped;

endmodule

@@ dv/vector_reduce_max_min_sum_core_test.sv @@
`timescale 1ns / 1ps

module vector_reduce_max_min_sum_core_test;
    import vrm_pkg::*;

    localparam int INDEX_W     = 10;
    localparam int DEPTH       = 1024;
    localparam int SRC_LIMIT   = 64;
    localparam int DRAIN       = 6;
    localparam int QUIET_LIMIT = 2000;

    localparam logic [DATA_W-1:0] MIN64 = 64'h8000_0000_0000_0000;
    localparam logic [DATA_W-1:0] MAX64 = 64'h7fff_ffff_ffff_ffff;
    localparam logic [DATA_W-1:0] ALL1  = 64'hffff_ffff_ffff_ffff;

    // one reduced word as it leaves the block
    typedef struct {
        logic [DATA_W-1:0]  value;
        logic [INDEX_W-1:0] index;
        logic               last;
    } reduced_word_t;

    // one entry of the feed: a word, or a hold until all results are back
    typedef struct {
        bit                hold;
        logic [DATA_W-1:0] value;
    } feed_t;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = REG_REDUCE_OP;
    logic [CFG_W-1:0]   i_cfg_data = '0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [DATA_W-1:0]  i_element_value = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic [DATA_W-1:0]  o_reduced_value;
    logic [INDEX_W-1:0] o_element_index;
    logic               o_last_element;

    feed_t         feed_q[$];
    reduced_word_t reduced_q[$];
    logic          word_taken = 1'b0;
    int            idle_pct = 16;
    int            mismatch_count = 0;
    int            quiet_cycles = 0;

    // shadow of the block: registers, counters, accumulators
    logic [OP_W-1:0]   m_op;
    logic              m_wide;
    logic [VLEN_W-1:0] m_len;
    logic [NSRC_W-1:0] m_nsrc;
    int unsigned       col_cnt;
    int unsigned       src_cnt;
    logic [DATA_W-1:0] acc_mem [0:DEPTH-1];

    vector_reduce_max_min_sum_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_element_value (i_element_value),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_reduced_value (o_reduced_value),
        .o_element_index (o_element_index),
        .o_last_element  (o_last_element)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic int unsigned eff_len(input logic [VLEN_W-1:0] v);
        if (v == 0) return 1;
        if (v > DEPTH) return DEPTH;
        return v;
    endfunction

    function automatic int unsigned eff_src(input logic [NSRC_W-1:0] v);
        if (v == 0) return 1;
        if (v > SRC_LIMIT) return SRC_LIMIT;
        return v;
    endfunction

    // fold one word into its accumulator; returns 1 when the index is complete
    function automatic bit reduce_word(input logic [DATA_W-1:0] raw,
                                       output reduced_word_t res);
        int unsigned len;
        int unsigned nsrc;
        int unsigned col;
        int unsigned src;
        logic [DATA_W-1:0] x;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] v;
        len  = eff_len(m_len);
        nsrc = eff_src(m_nsrc);
        col  = (col_cnt >= len) ? 0 : col_cnt;
        src  = (src_cnt >= nsrc) ? 0 : src_cnt;
        x    = m_wide ? raw : {{HALF_W{raw[HALF_W-1]}}, raw[HALF_W-1:0]};
        if (src == 0) begin
            v = x;
        end else begin
            a = acc_mem[col];
            case (m_op)
                OP_MAX:  v = ($signed(a) < $signed(x)) ? x : a;
                OP_MIN:  v = ($signed(x) < $signed(a)) ? x : a;
                default: v = a + x;
            endcase
            if (!m_wide) v = {{HALF_W{v[HALF_W-1]}}, v[HALF_W-1:0]};
        end
        acc_mem[col] = v;
        res.value = v;
        res.index = col[INDEX_W-1:0];
        res.last  = (col == len - 1);
        if (col + 1 >= len) begin
            col_cnt = 0;
            src_cnt = (src + 1 >= nsrc) ? 0 : src + 1;
        end else begin
            col_cnt = col + 1;
            src_cnt = src;
        end
        return (src == nsrc - 1);
    endfunction

    task automatic flag_mismatch(input string what);
        $display("mismatch at %0t ns: %s", $time, what);
        mismatch_count++;
    endtask

    // word driver: new words at the falling edge, a stalled word holds
    always @(negedge i_clk) begin : drive_words
        feed_t nxt;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            i_stall <= 1'b0;
        end else begin
            i_stall <= ($urandom_range(99) < idle_pct);
            if (!i_valid || word_taken) begin
                if (feed_q.size() != 0 && feed_q[0].hold) begin
                    i_valid <= 1'b0;
                    if (reduced_q.size() == 0) void'(feed_q.pop_front());
                end else if (feed_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
                    nxt = feed_q.pop_front();
                    i_valid <= 1'b1;
                    i_element_value <= nxt.value;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: shadow update on accepted words and writes, result check, watchdog
    always @(posedge i_clk) begin : watch_words
        reduced_word_t want;
        reduced_word_t fresh;
        if (!i_rst_n) begin
            word_taken <= 1'b0;
            m_op    = RST_REDUCE_OP;
            m_wide  = RST_WIDE_MODE;
            m_len   = RST_VECTOR_LENGTH;
            m_nsrc  = RST_NUM_SOURCES;
            col_cnt = 0;
            src_cnt = 0;
        end else begin
            word_taken <= i_valid && !o_stall;

            // compare an accepted result with the oldest expected one
            if (o_valid && !i_stall) begin
                if (reduced_q.size() == 0) begin
                    flag_mismatch($sformatf("unexpected result %h at index %0d",
                                            o_reduced_value, o_element_index));
                end else begin
                    want = reduced_q.pop_front();
                    if (o_reduced_value !== want.value)
                        flag_mismatch($sformatf("index %0d value %h, expected %h",
                                                want.index, o_reduced_value, want.value));
                    if (o_element_index !== want.index)
                        flag_mismatch($sformatf("index %0d, expected %0d",
                                                o_element_index, want.index));
                    if (o_last_element !== want.last)
                        flag_mismatch($sformatf("index %0d last flag %b, expected %b",
                                                want.index, o_last_element, want.last));
                end
            end

            // register writes restart the stream
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_REDUCE_OP:     m_op   = i_cfg_data[OP_W-1:0];
                    REG_WIDE_MODE:     m_wide = i_cfg_data[0];
                    REG_VECTOR_LENGTH: m_len  = i_cfg_data[VLEN_W-1:0];
                    REG_NUM_SOURCES:   m_nsrc = i_cfg_data[NSRC_W-1:0];
                    default: ;
                endcase
                col_cnt = 0;
                src_cnt = 0;
            end

            if (i_valid && !o_stall) begin
                if (reduce_word(i_element_value, fresh)) reduced_q.push_back(fresh);
            end

            // watchdog on cycles without any transfer
            if ((i_valid && !o_stall) || (o_valid && !i_stall) || i_cfg_we)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
                $display("** vector_reduce_max_min_sum_core: FAILED **");
                $finish;
            end
        end
    end

    task automatic queue_word(input logic [DATA_W-1:0] v);
        feed_q.push_back('{hold: 1'b0, value: v});
    endtask

    task automatic queue_hold();
        feed_q.push_back('{hold: 1'b1, value: '0});
    endtask

    // wait for the feed and the results to drain, then let the pipe empty
    // checked at the rising edge, where the driver's outputs are stable
    task automatic settle();
        @(posedge i_clk);
        while (feed_q.size() != 0 || i_valid || reduced_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN) @(negedge i_clk);
    endtask

    task automatic program_regs(input logic [CFG_W-1:0] op_d,
                                input logic [CFG_W-1:0] wide_d,
                                input logic [CFG_W-1:0] len_d,
                                input logic [CFG_W-1:0] nsrc_d);
        settle();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_REDUCE_OP;
        i_cfg_data  <= op_d;
        @(negedge i_clk);
        i_cfg_index <= REG_WIDE_MODE;
        i_cfg_data  <= wide_d;
        @(negedge i_clk);
        i_cfg_index <= REG_VECTOR_LENGTH;
        i_cfg_data  <= len_d;
        @(negedge i_clk);
        i_cfg_index <= REG_NUM_SOURCES;
        i_cfg_data  <= nsrc_d;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // element mix: extremes of both widths, small values, full random
    function automatic logic [DATA_W-1:0] pick_value();
        logic [DATA_W-1:0] v;
        case ($urandom_range(9))
            0: v = MIN64;
            1: v = MAX64;
            2: v = {$urandom, 32'h8000_0000};
            3: v = {$urandom, 32'h7fff_ffff};
            4: v = '0;
            5: v = ALL1;
            6: begin
                v = $urandom_range(20);
                v = v - 10;
            end
            default: v = {$urandom, $urandom};
        endcase
        return v;
    endfunction

    initial begin : run_phases
        int unsigned len_e;
        int unsigned src_e;
        int unsigned words;
        int unsigned hold_at;
        int          rand_words;
        logic [CFG_W-1:0] len_d;
        logic [CFG_W-1:0] nsrc_d;
        logic [CFG_W-1:0] op_d;
        logic [CFG_W-1:0] wide_d;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: 64-bit sum, one word vectors, one source
        queue_word(MIN64);
        queue_word(MAX64);
        queue_word(64'h0123_4567_89ab_cdef);

        // 64-bit max over two sources, then a partial vector cut by a write
        program_regs(11'(OP_MAX), 11'd1, 11'd2, 11'd2);
        queue_word(MIN64);
        queue_word(64'd5);
        queue_word(ALL1);
        queue_word(MAX64);
        queue_word(64'd77);

        // 32-bit min over three sources, junk in the upper half
        program_regs(11'(OP_MIN), 11'd0, 11'd2, 11'd3);
        queue_word(64'hdead_beef_7fff_ffff);
        queue_word(64'h1234_5678_8000_0000);
        queue_hold();
        queue_word(64'hffff_ffff_0000_0001);
        queue_word(64'h0000_0000_ffff_ffff);
        queue_word(64'h8000_0000_0000_0000);
        queue_word(64'h7fff_ffff_8000_0001);

        // unused op code sums; zero length acts as one; 32-bit wrap
        program_regs(11'd3, 11'd0, 11'd0, 11'd2);
        queue_word(64'h0000_0000_7fff_ffff);
        queue_word(64'hffff_0000_0000_0001);
        queue_word(64'h5555_5555_8000_0000);
        queue_word(ALL1);

        // 64-bit wrapping sum
        program_regs(11'(OP_SUM), 11'd1, 11'd1, 11'd2);
        queue_word(MAX64);
        queue_word(64'd1);
        queue_word(MIN64);
        queue_word(ALL1);

        // zero sources act as one
        program_regs(11'(OP_MAX), 11'd1, 11'd0, 11'd0);
        queue_word(64'hc000_0000_0000_0000);
        queue_word(64'h3fff_ffff_ffff_ffff);

        // random settings, mostly whole vectors, some cut short
        rand_words = 0;
        while (rand_words < 400) begin
            op_d   = {9'($urandom), 2'($urandom_range(3))};
            wide_d = {10'($urandom), 1'($urandom_range(1))};
            case ($urandom_range(9))
                0:       nsrc_d = {4'($urandom), 7'd0};
                1:       nsrc_d = {4'($urandom), 7'($urandom_range(64, 127))};
                default: nsrc_d = {4'($urandom), 7'($urandom_range(1, 6))};
            endcase
            src_e = eff_src(nsrc_d[NSRC_W-1:0]);
            if (src_e > 8)
                len_d = 11'($urandom_range(1, 2));
            else if ($urandom_range(9) == 0)
                len_d = 11'd0;
            else
                len_d = 11'($urandom_range(1, 12));
            len_e = eff_len(len_d);
            program_regs(op_d, wide_d, len_d, nsrc_d);
            words = len_e * src_e * ((src_e > 8) ? 1 : $urandom_range(1, 4));
            if ($urandom_range(4) == 0 && len_e * src_e > 1)
                words += $urandom_range(1, len_e * src_e - 1);
            hold_at = ($urandom_range(2) == 0) ? $urandom_range(words - 1) : words;
            for (int unsigned k = 0; k < words; k++) begin
                if (k == hold_at) queue_hold();
                queue_word(pick_value());
            end
            rand_words += words;
        end

        // oversized source count saturates, upper data bits ignored
        program_regs(11'($urandom_range(3)), 11'($urandom_range(1)), 11'd2, 11'h7ff);
        for (int k = 0; k < 128; k++) queue_word(pick_value());

        // full length cut short by a write
        program_regs(11'(OP_SUM), 11'd0, 11'd1024, 11'd1);
        for (int k = 0; k < 30; k++) queue_word(pick_value());

        // oversized length saturates; a long run with no idling
        program_regs(11'($urandom_range(3)), 11'($urandom_range(1)), 11'h7ff, 11'd1);
        idle_pct = 0;
        for (int k = 0; k < 1025; k++) begin
            if (k == 600) queue_hold();
            queue_word(pick_value());
        end
        settle();
        idle_pct = 16;

        // a last short phase with random stalls again
        program_regs(11'(OP_MIN), 11'd1, 11'd3, 11'd2);
        for (int k = 0; k < 12; k++) queue_word(pick_value());

        settle();
        if (mismatch_count == 0) begin
            $display("** vector_reduce_max_min_sum_core: PASSED **");
        end else begin
            $display("** vector_reduce_max_min_sum_core: FAILED **");
        end
        $finish;
    end

endmodule

@@ sim.f @@
design/vrm_pkg.sv
design/vrm_ram.sv
design/vrm_seq.sv
design/vrm_alu.sv
design/vector_reduce_max_min_sum_core.sv
dv/vector_reduce_max_min_sum_core_test.sv
